FILE: rtl/rcxy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcxy_pkg
// Shared widths, matrix coefficients, the sRGB linearization ROM and the
// control struct for the sRGB to CIE xy chromaticity core.
// ----------------------------------------------------------------------------
package rcxy_pkg;

    localparam int LINEAR_BITS = 16;
    localparam int LIN_W       = LINEAR_BITS + 1;
    localparam int COEF_W      = 20;
    localparam int PROD_W      = LIN_W + COEF_W;
    localparam int TRI_W       = LIN_W + COEF_W + 1;
    localparam int SUM_W       = LIN_W + COEF_W + 2;
    localparam int Q_W         = 10;
    localparam int NUM_W       = SUM_W + Q_W;

    localparam logic [Q_W-1:0] MILLI_MAX   = Q_W'(1000);
    localparam logic [NUM_W-1:0] MILLI_SCALE = NUM_W'(1000);

    localparam logic [0:2][0:2][COEF_W-1:0] COEF_Q20 = '{
        '{COEF_W'(696790), COEF_W'(161820), COEF_W'(169899)},
        '{COEF_W'(297671), COEF_W'(700903), COEF_W'(50001)},
        '{COEF_W'(92),     COEF_W'(75823),  COEF_W'(1033937)}
    };

    typedef logic [255:0][LIN_W-1:0] t_lin_rom;

    typedef struct packed {
        logic valid;
        logic black;
    } t_ctrl;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    function automatic t_lin_rom build_lin_rom();
        t_lin_rom    rom;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p;
        logic [63:0] lin30;
        rom = '0;
        for (int c = 0; c < 256; c++) begin
            if (c <= 10) begin
                lin30 = ((64'(c) << 30) * 64'd10) / 64'd32946;
            end else begin
                t  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
                t2 = (t * t) >> 30;
                r  = '0;
                for (int b = 30; b >= 0; b--) begin
                    cand = r | (64'd1 << b);
                    if (cand <= Q30_ONE) begin
                        p = cand;
                        for (int j = 0; j < 4; j++) begin
                            p = (p * cand) >> 30;
                        end
                        if (p <= t2) begin
                            r = cand;
                        end
                    end
                end
                lin30 = (t2 * r) >> 30;
            end
            rom[c] = LIN_W'(lin30 >> (30 - LINEAR_BITS));
        end
        return rom;
    endfunction

    localparam t_lin_rom LIN_ROM = build_lin_rom();

endpackage

FILE: rtl/rgb_to_cie_xy_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cie_xy_core
// Converts one 8-bit sRGB triple per cycle to CIE 1931 chromaticity x and y,
// scaled by 1000, with a flag for black input.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         start, busy          i_red_in, i_green_in, i_blue_in
//  result    out        o_done (one cycle)   o_x_milli, o_y_milli, o_black_flag
//
//  A request is taken when start is high and busy is low; one per cycle.
//  Each result passes through these registers in order: ROM lookup, matrix
//  multiply, row sums, total and scaling, ten divider stages, output register.
//  busy is high only during reset and the cycle after it.
//  The receiver cannot stall; results are strobed once on o_done.
// ----------------------------------------------------------------------------
module rgb_to_cie_xy_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    output logic       o_done,
    output logic [9:0] o_x_milli,
    output logic [9:0] o_y_milli,
    output logic       o_black_flag
);

    logic                        r_ready;
    logic                        accept;

    logic                        r_s1_vld;
    logic [rcxy_pkg::LIN_W-1:0]  r_s1_lin  [0:2];
    logic                        r_s2_vld;
    logic [rcxy_pkg::PROD_W-1:0] r_s2_prod [0:2][0:2];
    logic                        r_s3_vld;
    logic [rcxy_pkg::TRI_W-1:0]  r_s3_tri  [0:2];
    rcxy_pkg::t_ctrl             r_s4_ctrl;
    logic [rcxy_pkg::SUM_W-1:0]  r_s4_den;
    logic [rcxy_pkg::NUM_W-1:0]  r_s4_num_x;
    logic [rcxy_pkg::NUM_W-1:0]  r_s4_num_y;

    rcxy_pkg::t_ctrl             div_ctrl;
    logic [rcxy_pkg::Q_W-1:0]    div_q_x;
    logic [rcxy_pkg::Q_W-1:0]    div_q_y;

    logic                        r_done;
    logic [9:0]                  r_x_milli;
    logic [9:0]                  r_y_milli;
    logic                        r_black;

    assign busy   = ~r_ready;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_ctrl <= '0;
            r_done    <= 1'b0;
        end else begin
            r_ready         <= 1'b1;
            r_s1_vld        <= accept;
            r_s2_vld        <= r_s1_vld;
            r_s3_vld        <= r_s2_vld;
            r_s4_ctrl.valid <= r_s3_vld;
            r_s4_ctrl.black <= (r_s3_tri[0] == '0) && (r_s3_tri[1] == '0)
                               && (r_s3_tri[2] == '0);
            r_done          <= div_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lin[0] <= rcxy_pkg::LIN_ROM[i_red_in];
        r_s1_lin[1] <= rcxy_pkg::LIN_ROM[i_green_in];
        r_s1_lin[2] <= rcxy_pkg::LIN_ROM[i_blue_in];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_s2_prod[r][c] <= rcxy_pkg::PROD_W'(r_s1_lin[c])
                                   * rcxy_pkg::PROD_W'(rcxy_pkg::COEF_Q20[r][c]);
            end
            r_s3_tri[r] <= rcxy_pkg::TRI_W'(r_s2_prod[r][0])
                           + rcxy_pkg::TRI_W'(r_s2_prod[r][1])
                           + rcxy_pkg::TRI_W'(r_s2_prod[r][2]);
        end
        r_s4_den   <= rcxy_pkg::SUM_W'(r_s3_tri[0]) + rcxy_pkg::SUM_W'(r_s3_tri[1])
                      + rcxy_pkg::SUM_W'(r_s3_tri[2]);
        r_s4_num_x <= rcxy_pkg::NUM_W'(r_s3_tri[0]) * rcxy_pkg::MILLI_SCALE;
        r_s4_num_y <= rcxy_pkg::NUM_W'(r_s3_tri[1]) * rcxy_pkg::MILLI_SCALE;
    end

    rcxy_milli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_s4_ctrl),
        .i_den   (r_s4_den),
        .i_num_x (r_s4_num_x),
        .i_num_y (r_s4_num_y),
        .o_ctrl  (div_ctrl),
        .o_q_x   (div_q_x),
        .o_q_y   (div_q_y)
    );

    always_ff @(posedge i_clk) begin
        r_black <= div_ctrl.black;
        if (div_ctrl.black) begin
            r_x_milli <= '0;
            r_y_milli <= '0;
        end else begin
            r_x_milli <= (div_q_x > rcxy_pkg::MILLI_MAX) ? rcxy_pkg::MILLI_MAX : div_q_x;
            r_y_milli <= (div_q_y > rcxy_pkg::MILLI_MAX) ? rcxy_pkg::MILLI_MAX : div_q_y;
        end
    end

    assign o_done       = r_done;
    assign o_x_milli    = r_x_milli;
    assign o_y_milli    = r_y_milli;
    assign o_black_flag = r_black;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 15))
        else $error("result strobe without a request 15 cycles earlier");

    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_black_flag) |-> (o_x_milli == 10'd0 && o_y_milli == 10'd0))
        else $error("black result with nonzero chromaticity");

    a_xy_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_black_flag) |->
            (({1'b0, o_x_milli} + {1'b0, o_y_milli}) <= 11'd1000))
        else $error("chromaticity x plus y exceeds 1000");

endmodule

FILE: rtl/rcxy_milli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcxy_milli_div
// Pipelined restoring divider: one quotient bit per stage for two numerators
// over a shared denominator, control bits travel alongside.
// ----------------------------------------------------------------------------
module rcxy_milli_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rcxy_pkg::t_ctrl            i_ctrl,
    input  logic [rcxy_pkg::SUM_W-1:0] i_den,
    input  logic [rcxy_pkg::NUM_W-1:0] i_num_x,
    input  logic [rcxy_pkg::NUM_W-1:0] i_num_y,
    output rcxy_pkg::t_ctrl            o_ctrl,
    output logic [rcxy_pkg::Q_W-1:0]   o_q_x,
    output logic [rcxy_pkg::Q_W-1:0]   o_q_y
);

    localparam int QW = rcxy_pkg::Q_W;

    rcxy_pkg::t_ctrl            s_ctrl  [0:QW-1];
    logic [rcxy_pkg::SUM_W-1:0] s_den   [0:QW-1];
    logic [rcxy_pkg::NUM_W-1:0] s_rem_x [0:QW-1];
    logic [rcxy_pkg::NUM_W-1:0] s_rem_y [0:QW-1];
    logic [QW-1:0]              s_q_x   [0:QW-1];
    logic [QW-1:0]              s_q_y   [0:QW-1];

    logic [rcxy_pkg::NUM_W-1:0] n_rem_x [0:QW-1];
    logic [rcxy_pkg::NUM_W-1:0] n_rem_y [0:QW-1];
    logic [QW-1:0]              n_q_x   [0:QW-1];
    logic [QW-1:0]              n_q_y   [0:QW-1];

    rcxy_pkg::t_ctrl            r_ctrl  [0:QW-1];
    logic [rcxy_pkg::SUM_W-1:0] r_den   [0:QW-1];
    logic [rcxy_pkg::NUM_W-1:0] r_rem_x [0:QW-1];
    logic [rcxy_pkg::NUM_W-1:0] r_rem_y [0:QW-1];
    logic [QW-1:0]              r_q_x   [0:QW-1];
    logic [QW-1:0]              r_q_y   [0:QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int SH = QW - 1 - i;
        logic [rcxy_pkg::NUM_W-1:0] d_sh;

        if (i == 0) begin : g_first
            assign s_ctrl[i]  = i_ctrl;
            assign s_den[i]   = i_den;
            assign s_rem_x[i] = i_num_x;
            assign s_rem_y[i] = i_num_y;
            assign s_q_x[i]   = '0;
            assign s_q_y[i]   = '0;
        end else begin : g_next
            assign s_ctrl[i]  = r_ctrl[i-1];
            assign s_den[i]   = r_den[i-1];
            assign s_rem_x[i] = r_rem_x[i-1];
            assign s_rem_y[i] = r_rem_y[i-1];
            assign s_q_x[i]   = r_q_x[i-1];
            assign s_q_y[i]   = r_q_y[i-1];
        end

        assign d_sh = rcxy_pkg::NUM_W'(s_den[i]) << SH;

        always_comb begin
            n_rem_x[i] = s_rem_x[i];
            n_q_x[i]   = s_q_x[i];
            if (s_rem_x[i] >= d_sh) begin
                n_rem_x[i] = s_rem_x[i] - d_sh;
                n_q_x[i]   = s_q_x[i] | (QW'(1) << SH);
            end
            n_rem_y[i] = s_rem_y[i];
            n_q_y[i]   = s_q_y[i];
            if (s_rem_y[i] >= d_sh) begin
                n_rem_y[i] = s_rem_y[i] - d_sh;
                n_q_y[i]   = s_q_y[i] | (QW'(1) << SH);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[i] <= '0;
            end else begin
                r_ctrl[i] <= s_ctrl[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[i]   <= s_den[i];
            r_rem_x[i] <= n_rem_x[i];
            r_rem_y[i] <= n_rem_y[i];
            r_q_x[i]   <= n_q_x[i];
            r_q_y[i]   <= n_q_y[i];
        end
    end

    assign o_ctrl = r_ctrl[QW-1];
    assign o_q_x  = r_q_x[QW-1];
    assign o_q_y  = r_q_y[QW-1];

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rgb_to_cie_xy_core. Sends directed corner triples
// and then random ones, with random idle bursts on the request side. Each
// chromaticity result is compared field by field with an in-bench prediction
// of the gamma ROM, the color matrix and the milli-scaled division.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int QUIET_TAIL     = 200;

    typedef struct packed {
        logic [rcxy_pkg::Q_W-1:0] x_milli;
        logic [rcxy_pkg::Q_W-1:0] y_milli;
        logic                     black_flag;
    } t_xy_result;

    class chroma_scoreboard;
        bit [63:0]  gamma_lut [256];
        bit [63:0]  rgb_to_xyz [3][3];
        t_xy_result expected_q [$];
        int unsigned mismatches;

        function new();
            bit [63:0] t;
            bit [63:0] t2;
            bit [63:0] root;
            bit [63:0] cand;
            bit [63:0] lin30;
            mismatches = 0;
            rgb_to_xyz[0][0] = 64'd696790;
            rgb_to_xyz[0][1] = 64'd161820;
            rgb_to_xyz[0][2] = 64'd169899;
            rgb_to_xyz[1][0] = 64'd297671;
            rgb_to_xyz[1][1] = 64'd700903;
            rgb_to_xyz[1][2] = 64'd50001;
            rgb_to_xyz[2][0] = 64'd92;
            rgb_to_xyz[2][1] = 64'd75823;
            rgb_to_xyz[2][2] = 64'd1033937;
            for (int code = 0; code < 256; code++) begin
                if (code <= 10) begin
                    lin30 = ((64'(code) << 30) * 64'd10) / 64'd32946;
                end else begin
                    t    = ((64'(code) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
                    t2   = (t * t) >> 30;
                    root = 64'd0;
                    for (int b = 30; b >= 0; b--) begin
                        cand = root | (64'd1 << b);
                        if (cand <= (64'd1 << 30) && pow5_q30(cand) <= t2) begin
                            root = cand;
                        end
                    end
                    lin30 = (t2 * root) >> 30;
                end
                gamma_lut[code] = lin30 >> (30 - rcxy_pkg::LINEAR_BITS);
            end
        endfunction

        function bit [63:0] pow5_q30(bit [63:0] v);
            bit [63:0] p;
            p = v;
            for (int k = 0; k < 4; k++) begin
                p = (p * v) >> 30;
            end
            return p;
        endfunction

        function logic [rcxy_pkg::Q_W-1:0] milli_of(bit [63:0] num, bit [63:0] den);
            bit [63:0] q;
            q = (num * 64'd1000) / den;
            if (q > 64'd1000) begin
                q = 64'd1000;
            end
            return rcxy_pkg::Q_W'(q);
        endfunction

        function t_xy_result predict_xy(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            bit [63:0]  lin [3];
            bit [63:0]  xyz [3];
            bit [63:0]  total;
            t_xy_result res;
            lin[0] = gamma_lut[r];
            lin[1] = gamma_lut[g];
            lin[2] = gamma_lut[b];
            for (int i = 0; i < 3; i++) begin
                xyz[i] = 64'd0;
                for (int j = 0; j < 3; j++) begin
                    xyz[i] += lin[j] * rgb_to_xyz[i][j];
                end
            end
            total = xyz[0] + xyz[1] + xyz[2];
            if (total == 64'd0) begin
                res.x_milli    = '0;
                res.y_milli    = '0;
                res.black_flag = 1'b1;
            end else begin
                res.x_milli    = milli_of(xyz[0], total);
                res.y_milli    = milli_of(xyz[1], total);
                res.black_flag = 1'b0;
            end
            return res;
        endfunction

        function void note_request(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            expected_q.push_back(predict_xy(r, g, b));
        endfunction

        function void check_result(logic [rcxy_pkg::Q_W-1:0] x,
                                   logic [rcxy_pkg::Q_W-1:0] y, logic flag);
            t_xy_result exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: x=%0d y=%0d black=%0d", x, y, flag);
                end
                return;
            end
            exp_res = expected_q.pop_front();
            if (x !== exp_res.x_milli || y !== exp_res.y_milli ||
                flag !== exp_res.black_flag) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected x=%0d y=%0d black=%0d, %s",
                             exp_res.x_milli, exp_res.y_milli, exp_res.black_flag,
                             $sformatf("got x=%0d y=%0d black=%0d", x, y, flag));
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_red_in;
    logic [7:0] i_green_in;
    logic [7:0] i_blue_in;
    logic       o_done;
    logic [9:0] o_x_milli;
    logic [9:0] o_y_milli;
    logic       o_black_flag;

    chroma_scoreboard sb;
    int unsigned      stall_cycles;

    rgb_to_cie_xy_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_done       (o_done),
        .o_x_milli    (o_x_milli),
        .o_y_milli    (o_y_milli),
        .o_black_flag (o_black_flag)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (start === 1'b1 && busy === 1'b0) begin
            sb.note_request(i_red_in, i_green_in, i_blue_in);
        end
        if (o_done === 1'b1) begin
            sb.check_result(o_x_milli, o_y_milli, o_black_flag);
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        @(negedge i_clk);
        start      <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_red_in   <= 8'($urandom);
            i_green_in <= 8'($urandom);
            i_blue_in  <= 8'($urandom);
        end
    endtask

    function automatic logic [7:0] pick_code(int mode);
        case (mode)
            0: begin
                case ($urandom_range(0, 5))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd10;
                    3: return 8'd11;
                    4: return 8'd254;
                    default: return 8'd255;
                endcase
            end
            1: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
            2: return 8'($urandom_range(0, 12));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int mode;
        sb           = new();
        stall_cycles = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_red_in     = 8'd0;
        i_green_in   = 8'd0;
        i_blue_in    = 8'd0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0,   8'd0);
        send_rgb(8'd0,   8'd255, 8'd0);
        send_rgb(8'd0,   8'd0,   8'd255);
        send_rgb(8'd1,   8'd0,   8'd0);
        send_rgb(8'd0,   8'd1,   8'd0);
        send_rgb(8'd0,   8'd0,   8'd1);
        idle_cycles(3);
        send_rgb(8'd10,  8'd10,  8'd10);
        send_rgb(8'd11,  8'd11,  8'd11);
        send_rgb(8'd10,  8'd11,  8'd12);
        send_rgb(8'd255, 8'd255, 8'd0);
        send_rgb(8'd255, 8'd0,   8'd255);
        send_rgb(8'd0,   8'd255, 8'd255);
        send_rgb(8'd1,   8'd1,   8'd1);
        idle_cycles(1);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd254, 8'd1,   8'd0);
        send_rgb(8'd170, 8'd85,  8'd42);
        send_rgb(8'd85,  8'd170, 8'd213);
        send_rgb(8'd0,   8'd0,   8'd0);
        send_rgb(8'd255, 8'd254, 8'd1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < RANDOM_ITEMS - QUIET_TAIL && (n / 100) % 3 != 2 &&
                $urandom_range(0, 5) == 0) begin
                idle_cycles($urandom_range(1, 15));
            end
            if ($urandom_range(0, 99) == 0) begin
                send_rgb(8'd0, 8'd0, 8'd0);
            end else begin
                mode = $urandom_range(0, 9);
                send_rgb(pick_code(mode), pick_code(mode), pick_code(mode));
            end
        end
        idle_cycles(1);

        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: rgb_to_cie_xy_core.f
rtl/rcxy_pkg.sv
rtl/rcxy_milli_div.sv
rtl/rgb_to_cie_xy_core.sv
sim/tb_top.sv
